### rtl/arcd_pkg.sv
// arcd_pkg: shared types and constants of the adaptive context residual decoder
// payload item structs, configuration indexes, accumulator command struct
// no dependencies
`timescale 1ns / 1ps

package arcd_pkg;

    localparam int ENERGY_FRACTION_BITS_DEF = 16;
    localparam int CTX_CAP                  = 30;
    localparam int STEREO_COUNT             = 2;

    localparam logic [1:0]  CHANNEL_COUNT_RESET = 2'd1;
    localparam logic [31:0] SMOOTHING_RESET     = 32'h8000_0000;

    typedef enum logic [1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_SMOOTHING     = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [27:0] extra_bits;
        logic        block_start;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sample;
        logic [4:0]         next_context;
    } t_out_item;

    // where a partial product lands in the accumulator
    typedef enum logic [1:0] {
        SH_ZERO,
        SH_WORD,
        SH_FRAC,
        SH_WORD_FRAC
    } t_acc_shift;

    typedef struct packed {
        logic       mul_en;
        logic       acc_en;
        logic       acc_sub;
        t_acc_shift shift;
    } t_mac_cmd;

endpackage

### rtl/arcd_mac.sv
// arcd_mac: registered 32x32 multiplier with a wide shift-and-accumulate stage
// depends on arcd_pkg (t_mac_cmd, t_acc_shift)
`timescale 1ns / 1ps

module arcd_mac #(
    parameter int ENERGY_FRACTION_BITS = arcd_pkg::ENERGY_FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  arcd_pkg::t_mac_cmd                  i_cmd,
    input  logic [31:0]                         i_op_a,
    input  logic [31:0]                         i_op_b,
    input  logic                                i_init_en,
    input  logic [32+ENERGY_FRACTION_BITS-1:0]  i_init_val,
    output logic [63:0]                         o_prod,
    output logic [97+ENERGY_FRACTION_BITS-1:0]  o_acc
);

    localparam int AW = 97 + ENERGY_FRACTION_BITS;

    logic [63:0]        r_prod;
    logic [AW-1:0]      r_acc;
    arcd_pkg::t_mac_cmd r_cmd_d;
    logic [AW-1:0]      w_ext;
    logic [AW-1:0]      w_addend;

    assign w_ext = AW'(r_prod);

    always_comb begin
        case (r_cmd_d.shift)
            arcd_pkg::SH_ZERO:      w_addend = w_ext;
            arcd_pkg::SH_WORD:      w_addend = w_ext << 32;
            arcd_pkg::SH_FRAC:      w_addend = w_ext << ENERGY_FRACTION_BITS;
            arcd_pkg::SH_WORD_FRAC: w_addend = w_ext << (32 + ENERGY_FRACTION_BITS);
            default:                w_addend = w_ext;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_d <= '0;
        end else begin
            r_cmd_d <= i_cmd.mul_en ? i_cmd : '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= 64'(i_op_a) * 64'(i_op_b);
        end
        if (i_init_en) begin
            r_acc <= AW'(i_init_val) << 32;
        end else if (r_cmd_d.acc_en) begin
            r_acc <= r_cmd_d.acc_sub ? (r_acc - w_addend) : (r_acc + w_addend);
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

### rtl/adaptive_context_residual_decoder.sv
// adaptive_context_residual_decoder: top level, symbol to residual sample and next context
// depends on arcd_pkg and arcd_mac
`timescale 1ns / 1ps

// Turns one range-decoded magnitude symbol plus its raw extra bits into a signed
// residual sample and the context index for the next symbol, keeping a smoothed
// energy per channel (mono, or two channels alternating sample by sample when
// channel_count is 2). Between acceptance and the result being offered, the
// energy update runs five products in series (code squared, two halves of
// energy times weight, two halves of the squared code times weight) through
// one registered 32x32 multiplier and its accumulator, followed by a
// saturating write-back and a two-step leading-one search for the context.
// o_in_stall is high from acceptance until the result is loaded into the output
// register; a result left waiting there does not hold off the next item.
// Configuration writes are always taken (o_cfg_ready is tied high) and are meant
// for idle periods only. Both energies and the channel phase reset to zero, and an
// item with block_start set clears them before it is processed.
module adaptive_context_residual_decoder #(
    parameter int ENERGY_FRACTION_BITS = arcd_pkg::ENERGY_FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  arcd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arcd_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int EW = 32 + ENERGY_FRACTION_BITS;
    localparam int AW = 97 + ENERGY_FRACTION_BITS;
    localparam logic [EW-1:0] ENERGY_CAP = {EW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_INC,
        S_MUL_E_LO,
        S_MUL_E_HI,
        S_MUL_Q_LO,
        S_MUL_Q_HI,
        S_DRAIN,
        S_WRITE,
        S_CTX,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [1:0]    r_channel_count;
    logic [31:0]   r_smooth;
    logic [EW-1:0] r_energy_first;
    logic [EW-1:0] r_energy_second;
    logic          r_phase;

    logic [31:0]   r_code;
    logic [31:0]   r_sample;
    logic [EW-1:0] r_e;
    logic          r_ch;
    logic          r_stereo;
    logic [63:0]   r_q;
    logic [1:0]    r_grp;
    logic [7:0]    r_byte;

    logic                r_out_valid;
    arcd_pkg::t_out_item r_out_item;

    logic                in_accept;
    logic                stereo;
    logic                acc_ch;
    logic [EW-1:0]       acc_e;
    logic [7:0]          sym8;
    logic [4:0]          esc_n;
    logic [33:0]         esc_val;
    logic [31:0]         code;

    arcd_pkg::t_mac_cmd  mac_cmd;
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic                init_en;
    logic [63:0]         prod;
    logic [AW-1:0]       acc;

    logic                sat;
    logic [EW-1:0]       e_new;
    logic [31:0]         ctx_v;
    logic [2:0]          byte_msb;
    logic [4:0]          ctx_raw;
    logic [4:0]          ctx;
    logic                out_free;

    function automatic logic [2:0] msb8(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (b[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign stereo      = (r_channel_count == 2'(arcd_pkg::STEREO_COUNT));

    // channel and starting energy of the incoming item
    assign acc_ch = i_in_item.block_start ? 1'b0 : (stereo && r_phase);
    assign acc_e  = i_in_item.block_start ? '0 : (acc_ch ? r_energy_second : r_energy_first);

    // escape code: leading one, three mantissa bits, n raw bits
    // the widest escapes put the leading one above bit 31, where it is dropped
    assign sym8    = i_in_item.symbol - 8'd8;
    assign esc_n   = sym8[7:3];
    assign esc_val = (34'd1 << (6'(esc_n) + 6'd3)) | (34'(sym8[2:0]) << esc_n)
                   | (34'(i_in_item.extra_bits) & ((34'd1 << esc_n) - 34'd1));
    assign code    = (i_in_item.symbol <= 8'd7) ? 32'(i_in_item.symbol) : esc_val[31:0];

    always_comb begin
        mac_cmd = '0;
        op_a    = r_code;
        op_b    = r_code;
        init_en = 1'b0;
        case (r_state)
            S_SQUARE: begin
                mac_cmd.mul_en = 1'b1;
                init_en        = 1'b1;
            end
            S_MUL_E_LO: begin
                mac_cmd = '{mul_en: 1'b1, acc_en: 1'b1, acc_sub: 1'b1,
                            shift: arcd_pkg::SH_ZERO};
                op_a    = r_e[31:0];
                op_b    = r_smooth;
            end
            S_MUL_E_HI: begin
                mac_cmd = '{mul_en: 1'b1, acc_en: 1'b1, acc_sub: 1'b1,
                            shift: arcd_pkg::SH_WORD};
                op_a    = 32'(r_e[EW-1:32]);
                op_b    = r_smooth;
            end
            S_MUL_Q_LO: begin
                mac_cmd = '{mul_en: 1'b1, acc_en: 1'b1, acc_sub: 1'b0,
                            shift: arcd_pkg::SH_FRAC};
                op_a    = r_q[31:0];
                op_b    = r_smooth;
            end
            S_MUL_Q_HI: begin
                mac_cmd = '{mul_en: 1'b1, acc_en: 1'b1, acc_sub: 1'b0,
                            shift: arcd_pkg::SH_WORD_FRAC};
                op_a    = r_q[63:32];
                op_b    = r_smooth;
            end
            default: begin
                mac_cmd = '0;
            end
        endcase
    end

    arcd_mac #(
        .ENERGY_FRACTION_BITS(ENERGY_FRACTION_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (mac_cmd),
        .i_op_a     (op_a),
        .i_op_b     (op_b),
        .i_init_en  (init_en),
        .i_init_val (r_e),
        .o_prod     (prod),
        .o_acc      (acc)
    );

    // drop the 32 weight fraction bits and saturate
    assign sat   = |acc[AW-1:32+EW];
    assign e_new = sat ? ENERGY_CAP : acc[32+EW-1:32];

    // integer energy of the next item's channel
    assign ctx_v    = r_phase ? r_energy_second[EW-1:ENERGY_FRACTION_BITS]
                              : r_energy_first[EW-1:ENERGY_FRACTION_BITS];
    assign byte_msb = msb8(r_byte);
    assign ctx_raw  = {r_grp, 3'b000} + 5'(byte_msb);
    assign ctx      = (ctx_raw > 5'(arcd_pkg::CTX_CAP)) ? 5'(arcd_pkg::CTX_CAP) : ctx_raw;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     n_state = in_accept ? S_SQUARE : S_IDLE;
            S_SQUARE:   n_state = S_INC;
            S_INC:      n_state = S_MUL_E_LO;
            S_MUL_E_LO: n_state = S_MUL_E_HI;
            S_MUL_E_HI: n_state = S_MUL_Q_LO;
            S_MUL_Q_LO: n_state = S_MUL_Q_HI;
            S_MUL_Q_HI: n_state = S_DRAIN;
            S_DRAIN:    n_state = S_WRITE;
            S_WRITE:    n_state = S_CTX;
            S_CTX:      n_state = S_DONE;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_channel_count <= arcd_pkg::CHANNEL_COUNT_RESET;
            r_smooth        <= arcd_pkg::SMOOTHING_RESET;
            r_energy_first  <= '0;
            r_energy_second <= '0;
            r_phase         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    arcd_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[1:0];
                    arcd_pkg::CFG_SMOOTHING:     r_smooth        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (in_accept && i_in_item.block_start) begin
                r_energy_first  <= '0;
                r_energy_second <= '0;
                r_phase         <= 1'b0;
            end

            if (r_state == S_WRITE) begin
                if (r_ch) begin
                    r_energy_second <= e_new;
                end else begin
                    r_energy_first  <= e_new;
                end
                r_phase <= r_stereo && !r_ch;
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (in_accept) begin
            r_code   <= code;
            r_sample <= (code >> 1) ^ {32{code[0]}};
            r_e      <= acc_e;
            r_ch     <= acc_ch;
            r_stereo <= stereo;
        end

        if (r_state == S_INC) begin
            r_q <= prod + 64'd1;
        end

        // first step of the leading-one search: pick the top nonzero byte
        if (r_state == S_CTX) begin
            if (ctx_v[31:24] != 8'd0) begin
                r_grp  <= 2'd3;
                r_byte <= ctx_v[31:24];
            end else if (ctx_v[23:16] != 8'd0) begin
                r_grp  <= 2'd2;
                r_byte <= ctx_v[23:16];
            end else if (ctx_v[15:8] != 8'd0) begin
                r_grp  <= 2'd1;
                r_byte <= ctx_v[15:8];
            end else begin
                r_grp  <= 2'd0;
                r_byte <= ctx_v[7:0];
            end
        end

        if (r_state == S_DONE && out_free) begin
            r_out_item.sample       <= r_sample;
            r_out_item.next_context <= ctx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a new item is held off for the whole update
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input accepted again while an update is running");

    // a result appears only out of the final state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result offered outside the final state");

    // context never exceeds its cap
    a_ctx_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.next_context <= 5'(arcd_pkg::CTX_CAP)))
        else $error("next context above cap");

    // mono never leaves the phase on the second channel after write-back
    a_mono_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && !r_stereo) |=> !r_phase)
        else $error("phase advanced in mono");

endmodule

### verif/arcd_residual_checker.sv
// arcd_residual_checker: watches the item, result and register channels of the decoder,
// predicts every result and compares it field by field with what the block delivers
// depends on arcd_pkg
`timescale 1ns / 1ps

module arcd_residual_checker #(
    parameter int ENERGY_FRACTION_BITS = arcd_pkg::ENERGY_FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  arcd_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  arcd_pkg::t_out_item i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_failures,
    output int                  o_pending
);

    localparam int EW = 32 + ENERGY_FRACTION_BITS;
    localparam logic [EW-1:0] ENERGY_MAX = '1;

    logic [EW-1:0]       energy [2];
    logic                phase;
    logic [1:0]          chan_count;
    logic [31:0]         weight;
    arcd_pkg::t_out_item residual_queue [$];
    arcd_pkg::t_out_item oldest;
    int                  failure_count = 0;
    int                  pending_count = 0;

    assign o_failures = failure_count;
    assign o_pending  = pending_count;

    function automatic logic [31:0] rebuild_code(input logic [7:0] sym, input logic [27:0] extra);
        logic [63:0] val;
        logic [63:0] mask;
        logic [63:0] mant;
        int          n;
        if (sym <= 8'd7) begin
            return {24'd0, sym};
        end
        n    = (int'(sym) - 8) >> 3;
        mant = 64'((sym - 8'd8) & 8'd7);
        mask = (64'd1 << n) - 64'd1;
        // bits asked for above the 28-bit field read as zero, wide escapes drop above bit 31
        val  = (64'd1 << (n + 3)) | (mant << n) | ({36'd0, extra} & mask);
        return val[31:0];
    endfunction

    function automatic logic [EW-1:0] smooth_energy(input logic [EW-1:0] e,
                                                    input logic [31:0] code,
                                                    input logic [31:0] w);
        logic [127:0] sq;
        logic [127:0] keep;
        logic [127:0] gain;
        logic [127:0] total;
        sq    = 128'(code) * 128'(code) + 128'd1;
        keep  = 128'(e) * ((128'd1 << 32) - 128'(w));
        gain  = (sq * 128'(w)) << ENERGY_FRACTION_BITS;
        total = (keep + gain) >> 32;
        if (total > 128'(ENERGY_MAX)) begin
            return ENERGY_MAX;
        end
        return total[EW-1:0];
    endfunction

    function automatic logic [4:0] context_index(input logic [EW-1:0] e);
        logic [31:0] whole;
        int          idx;
        whole = e[EW-1 -: 32];
        idx   = 0;
        // integer part 0 or 1 stays at context 0
        for (int b = 1; b < 32; b++) begin
            if (whole[b]) begin
                idx = b;
            end
        end
        if (idx > arcd_pkg::CTX_CAP) begin
            idx = arcd_pkg::CTX_CAP;
        end
        return 5'(idx);
    endfunction

    task automatic predict_residual(input arcd_pkg::t_in_item it);
        logic                stereo;
        logic [31:0]         code;
        arcd_pkg::t_out_item r;
        stereo = (chan_count == 2'(arcd_pkg::STEREO_COUNT));
        if (it.block_start) begin
            energy[0] = '0;
            energy[1] = '0;
            phase     = 1'b0;
        end
        if (!stereo) begin
            phase = 1'b0;
        end
        code           = rebuild_code(it.symbol, it.extra_bits);
        r.sample       = (code >> 1) ^ {32{code[0]}};
        energy[phase]  = smooth_energy(energy[phase], code, weight);
        phase          = stereo ? ~phase : 1'b0;
        r.next_context = context_index(energy[phase]);
        residual_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            energy[0]  = '0;
            energy[1]  = '0;
            phase      = 1'b0;
            chan_count = arcd_pkg::CHANNEL_COUNT_RESET;
            weight     = arcd_pkg::SMOOTHING_RESET;
            residual_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    arcd_pkg::CFG_CHANNEL_COUNT: chan_count = i_cfg_data[1:0];
                    arcd_pkg::CFG_SMOOTHING:     weight     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (residual_queue.size() == 0) begin
                    $error("result item with none predicted: sample %0d next_context %0d",
                           i_out_item.sample, i_out_item.next_context);
                    failure_count++;
                end else begin
                    oldest = residual_queue.pop_front();
                    if (i_out_item.sample !== oldest.sample) begin
                        $error("sample: expected %0d actual %0d",
                               oldest.sample, i_out_item.sample);
                        failure_count++;
                    end
                    if (i_out_item.next_context !== oldest.next_context) begin
                        $error("next_context: expected %0d actual %0d",
                               oldest.next_context, i_out_item.next_context);
                        failure_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_residual(i_in_item);
            end
        end
        pending_count = residual_queue.size();
    end

endmodule

### verif/adaptive_context_residual_decoder_tb.sv
// adaptive_context_residual_decoder_tb: stimulus and verdict for the residual decoder
// directed escapes and block starts, then random phases over channel modes and weights
// depends on arcd_pkg, adaptive_context_residual_decoder and arcd_residual_checker
`timescale 1ns / 1ps

module adaptive_context_residual_decoder_tb;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int PHASE_COUNT     = 9;
    localparam int ITEMS_PER_PHASE = 200;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    arcd_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    arcd_pkg::t_out_item o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = arcd_pkg::CFG_CHANNEL_COUNT;
    logic [31:0]         i_cfg_data  = '0;

    int failures;
    int pending;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int items_sent    = 0;
    int cfg_writes    = 0;
    int quiet_cycles  = 0;
    int drift_level   = 40;

    int          count_table [PHASE_COUNT] = '{2, 1, 2, 0, 2, 3, 2, 1, 2};
    logic [31:0] phase_weight;

    always #5 i_clk = ~i_clk;

    adaptive_context_residual_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    arcd_residual_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic arcd_pkg::t_in_item make_item(input logic [7:0] sym,
                                                     input logic [27:0] extra,
                                                     input logic start);
        arcd_pkg::t_in_item it;
        it.symbol      = sym;
        it.extra_bits  = extra;
        it.block_start = start;
        return it;
    endfunction

    function automatic arcd_pkg::t_in_item random_item(inout int level);
        arcd_pkg::t_in_item it;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            it.symbol = 8'($urandom_range(255));
        end else if (pick < 50) begin
            it.symbol = 8'($urandom_range(23));
        end else begin
            // slowly drifting class keeps the energy settled so contexts spread out
            level = level + int'($urandom_range(8)) - 4;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            it.symbol = 8'(level);
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            it.extra_bits = 28'($urandom());
        end else if (pick < 85) begin
            it.extra_bits = '0;
        end else begin
            it.extra_bits = '1;
        end
        it.block_start = ($urandom_range(99) < 3);
        return it;
    endfunction

    task automatic write_reg(input arcd_pkg::t_cfg_index idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic push_item(input arcd_pkg::t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // registers change only once every predicted result has drained
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(arcd_pkg::CFG_CHANNEL_COUNT, 32'd1);
        write_reg(arcd_pkg::CFG_SMOOTHING, arcd_pkg::SMOOTHING_RESET);
        push_item(make_item(8'd0, 28'd0, 1'b1));
        for (int s = 1; s <= 7; s++) begin
            push_item(make_item(8'(s), 28'hFFF_FFFF, 1'b0));
        end
        push_item(make_item(8'd8, 28'hFFF_FFFF, 1'b0));
        push_item(make_item(8'd15, 28'd0, 1'b0));
        push_item(make_item(8'd16, 28'hFFF_FFFF, 1'b0));
        push_item(make_item(8'd24, 28'h555_5555, 1'b0));
        push_item(make_item(8'd239, 28'hFFF_FFFF, 1'b0));
        // widest escapes overflow the 32-bit code and saturate the energy
        push_item(make_item(8'd240, 28'hFFF_FFFF, 1'b0));
        push_item(make_item(8'd255, 28'hFFF_FFFF, 1'b0));
        push_item(make_item(8'd248, 28'd0, 1'b0));
        push_item(make_item(8'd0, 28'd0, 1'b1));
        push_item(make_item(8'd100, 28'hAAA_AAAA, 1'b0));
        settle();

        // zero weight holds the energy
        write_reg(arcd_pkg::CFG_SMOOTHING, 32'd0);
        push_item(make_item(8'd200, 28'h123_4567, 1'b0));
        push_item(make_item(8'd5, 28'd0, 1'b0));
        settle();

        write_reg(arcd_pkg::CFG_CHANNEL_COUNT, 32'(arcd_pkg::STEREO_COUNT));
        write_reg(arcd_pkg::CFG_SMOOTHING, 32'hFFFF_FFFF);
        push_item(make_item(8'd120, 28'd0, 1'b1));
        push_item(make_item(8'd3, 28'd0, 1'b0));
        push_item(make_item(8'd4, 28'd0, 1'b0));
        push_item(make_item(8'd64, 28'hFFF_FFFF, 1'b1));
        settle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 5)
                0: phase_weight = arcd_pkg::SMOOTHING_RESET;
                1: phase_weight = 32'd60774;
                2: phase_weight = $urandom_range(32'h8000_0000, 32'd60774);
                3: phase_weight = 32'd0;
                default: phase_weight = 32'hFFFF_FFFF;
            endcase
            write_reg(arcd_pkg::CFG_CHANNEL_COUNT, 32'(count_table[p]));
            write_reg(arcd_pkg::CFG_SMOOTHING, phase_weight);
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 58; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 58; end
                default: begin in_idle_pct = 22; out_stall_pct = 22; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                push_item(random_item(drift_level));
            end
            settle();
            out_stall_pct = 0;
        end

        $display("tb: %0d items in %0d random phases plus directed escapes, %0d register writes",
                 items_sent, PHASE_COUNT, cfg_writes);
        $display("tb: mono and stereo, weights zero to full scale, symbols 0 to 255");
        if (failures == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
